// ----- rtl/coap_message_parser_assert.svh -----
// Assertion macros for the CoAP message parser.
// Included by the RTL file that carries concurrent assertions (coap_message_parser); no dependencies.
`ifndef COAP_MESSAGE_PARSER_ASSERT_SVH
`define COAP_MESSAGE_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, ignored while reset is asserted.
`define COAP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("coap parser assertion failed in %m");
// Checked property, active during reset as well.
`define COAP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("coap parser assertion failed in %m");
`else
`define COAP_ASSERT(label, clk, rst_n, prop)
`define COAP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// ----- rtl/coap_pkg.sv -----
// Shared types and constants of the CoAP message parser.
// Used by coap_decode and coap_message_parser; no dependencies.
package coap_pkg;

    // Parser phases.
    localparam logic [3:0] PH_HDR     = 4'd0;
    localparam logic [3:0] PH_TOKEN   = 4'd1;
    localparam logic [3:0] PH_OPT     = 4'd2;
    localparam logic [3:0] PH_D1      = 4'd3;
    localparam logic [3:0] PH_DHI     = 4'd4;
    localparam logic [3:0] PH_DLO     = 4'd5;
    localparam logic [3:0] PH_L1      = 4'd6;
    localparam logic [3:0] PH_LHI     = 4'd7;
    localparam logic [3:0] PH_LLO     = 4'd8;
    localparam logic [3:0] PH_VALUE   = 4'd9;
    localparam logic [3:0] PH_PAYLOAD = 4'd10;
    localparam logic [3:0] PH_SKIP    = 4'd11;

    // Event codes reported with every byte.
    localparam logic [2:0] EV_NONE      = 3'd0;
    localparam logic [2:0] EV_HEADER    = 3'd1;
    localparam logic [2:0] EV_TOKEN     = 3'd2;
    localparam logic [2:0] EV_OPT_BEGIN = 3'd3;
    localparam logic [2:0] EV_OPT_VALUE = 3'd4;
    localparam logic [2:0] EV_PAYLOAD   = 3'd5;

    // Verdict codes given on the last byte.
    localparam logic [1:0] VERDICT_OK    = 2'd0;
    localparam logic [1:0] VERDICT_RESET = 2'd1;
    localparam logic [1:0] VERDICT_RUNT  = 2'd2;

    // Protocol constants.
    localparam logic [7:0]  PAYLOAD_MARKER = 8'hFF;
    localparam logic [3:0]  EXT_ONE_NIB    = 4'd13;
    localparam logic [3:0]  EXT_TWO_NIB    = 4'd14;
    localparam logic [15:0] EXT_ONE_BASE   = 16'd13;
    localparam logic [15:0] EXT_TWO_BASE   = 16'd269;
    localparam logic [3:0]  TOKEN_MAX      = 4'd8;
    localparam logic [1:0]  COAP_VERSION   = 2'd1;
    localparam logic [2:0]  HDR_BYTES      = 3'd4;

    // Parser state carried from byte to byte.
    typedef struct packed {
        logic [3:0]  phase;
        logic [2:0]  header_count;
        logic [3:0]  token_left;
        logic [15:0] running_number;
        logic [15:0] delta_accum;
        logic [3:0]  length_nibble;
        logic [15:0] length_accum;
        logic [15:0] value_left;
        logic [1:0]  held_type;
        logic [7:0]  held_code;
        logic [15:0] held_id;
        logic [3:0]  held_token_len;
        logic        fault;
    } t_state;

    // One result per byte.
    typedef struct packed {
        logic [2:0]  event_res;
        logic [7:0]  byte_value;
        logic [1:0]  msg_type;
        logic [7:0]  msg_code;
        logic [15:0] msg_id;
        logic [3:0]  token_len;
        logic [15:0] option_number;
        logic [15:0] option_length;
        logic        done_res;
        logic [1:0]  verdict;
    } t_result;

    // State at reset and at the start of each datagram.
    function automatic t_state state_reset();
        t_state s;
        s       = '0;
        s.phase = PH_HDR;
        return s;
    endfunction

endpackage

// ----- rtl/coap_decode.sv -----
// Combinational per-byte step of the CoAP parser: next state and result.
// Depends on coap_pkg.
module coap_decode
    import coap_pkg::*;
(
    input  t_state      i_state,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output t_state      o_state,
    output t_result     o_result
);

    t_state  n_st;
    t_result res;
    logic    start_len;
    logic    finish_opt;
    logic    opt_valid;
    logic    hdr_ok;

    always_comb begin
        n_st       = i_state;
        res        = '0;
        start_len  = 1'b0;
        finish_opt = 1'b0;
        opt_valid  = 1'b0;

        // Phase-specific work on this byte.
        case (i_state.phase)
            PH_HDR: begin
                case (i_state.header_count[1:0])
                    2'd0: begin
                        n_st.held_type      = i_data_byte[5:4];
                        n_st.held_token_len = i_data_byte[3:0];
                        n_st.fault = (i_data_byte[7:6] != COAP_VERSION) ||
                                     (i_data_byte[3:0] > TOKEN_MAX);
                    end
                    2'd1: n_st.held_code = i_data_byte;
                    2'd2: n_st.held_id = {i_data_byte, 8'h00};
                    default: n_st.held_id = i_state.held_id | {8'h00, i_data_byte};
                endcase
                n_st.header_count = i_state.header_count + 3'd1;
                if (n_st.header_count >= HDR_BYTES) begin
                    res.event_res = EV_HEADER;
                    if (n_st.fault) begin
                        n_st.phase = PH_SKIP;
                    end else begin
                        n_st.token_left = n_st.held_token_len;
                        n_st.phase = (n_st.held_token_len != 4'd0) ? PH_TOKEN : PH_OPT;
                    end
                end
            end
            PH_TOKEN: begin
                res.event_res   = EV_TOKEN;
                res.byte_value  = i_data_byte;
                n_st.token_left = i_state.token_left - 4'd1;
                if (n_st.token_left == 4'd0) begin
                    n_st.phase = PH_OPT;
                end
            end
            PH_OPT: begin
                if (i_data_byte == PAYLOAD_MARKER) begin
                    n_st.phase = PH_PAYLOAD;
                end else begin
                    n_st.length_nibble = i_data_byte[3:0];
                    if (i_data_byte[7:4] == EXT_ONE_NIB) begin
                        n_st.phase = PH_D1;
                    end else if (i_data_byte[7:4] == EXT_TWO_NIB) begin
                        n_st.phase = PH_DHI;
                    end else begin
                        n_st.delta_accum = {12'h000, i_data_byte[7:4]};
                        start_len = 1'b1;
                    end
                end
            end
            PH_D1: begin
                n_st.delta_accum = EXT_ONE_BASE + {8'h00, i_data_byte};
                start_len = 1'b1;
            end
            PH_DHI: begin
                n_st.delta_accum = {i_data_byte, 8'h00};
                n_st.phase = PH_DLO;
            end
            PH_DLO: begin
                n_st.delta_accum = EXT_TWO_BASE + (i_state.delta_accum | {8'h00, i_data_byte});
                start_len = 1'b1;
            end
            PH_L1: begin
                n_st.length_accum = EXT_ONE_BASE + {8'h00, i_data_byte};
                finish_opt = 1'b1;
            end
            PH_LHI: begin
                n_st.length_accum = {i_data_byte, 8'h00};
                n_st.phase = PH_LLO;
            end
            PH_LLO: begin
                n_st.length_accum = EXT_TWO_BASE +
                                    (i_state.length_accum | {8'h00, i_data_byte});
                finish_opt = 1'b1;
            end
            PH_VALUE: begin
                res.event_res   = EV_OPT_VALUE;
                res.byte_value  = i_data_byte;
                opt_valid       = 1'b1;
                n_st.value_left = i_state.value_left - 16'd1;
                if (n_st.value_left == 16'd0) begin
                    n_st.phase = PH_OPT;
                end
            end
            PH_PAYLOAD: begin
                res.event_res  = EV_PAYLOAD;
                res.byte_value = i_data_byte;
            end
            default: begin
                n_st.phase = PH_SKIP;
            end
        endcase

        // The delta is known; the length nibble decides whether extension bytes follow.
        if (start_len) begin
            if (n_st.length_nibble == EXT_ONE_NIB) begin
                n_st.phase = PH_L1;
            end else if (n_st.length_nibble == EXT_TWO_NIB) begin
                n_st.phase = PH_LHI;
            end else begin
                n_st.length_accum = {12'h000, n_st.length_nibble};
                finish_opt = 1'b1;
            end
        end

        // The option header is complete on this byte.
        if (finish_opt) begin
            n_st.running_number = i_state.running_number + n_st.delta_accum;
            n_st.value_left     = n_st.length_accum;
            n_st.phase = (n_st.length_accum != 16'd0) ? PH_VALUE : PH_OPT;
            res.event_res = EV_OPT_BEGIN;
            opt_valid     = 1'b1;
        end

        // Header and option fields are shown only once they are known.
        hdr_ok = (n_st.header_count >= HDR_BYTES);
        if (hdr_ok) begin
            res.msg_type  = n_st.held_type;
            res.msg_code  = n_st.held_code;
            res.msg_id    = n_st.held_id;
            res.token_len = n_st.held_token_len;
        end
        if (opt_valid) begin
            res.option_number = n_st.running_number;
            res.option_length = n_st.length_accum;
        end

        // Verdict on the last byte, then back to the start of a datagram.
        if (i_is_last) begin
            res.done_res = 1'b1;
            if (!hdr_ok) begin
                res.verdict = VERDICT_RUNT;
            end else if (n_st.fault) begin
                res.verdict = VERDICT_RESET;
            end else if (n_st.phase inside {PH_OPT, PH_PAYLOAD}) begin
                res.verdict = VERDICT_OK;
            end else begin
                res.verdict = VERDICT_RESET;
            end
            n_st = state_reset();
        end
    end

    assign o_state  = n_st;
    assign o_result = res;

endmodule

// ----- rtl/coap_message_parser.sv -----
// Top level of the streaming CoAP message parser: input register, state, result register.
// Depends on coap_pkg, coap_decode and coap_message_parser_assert.svh.
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_ready    i_data_byte, i_is_last
// result    out        o_out_valid / i_out_ready  o_event_res ... o_verdict
//
// One result per byte; a new byte is taken every cycle unless the result side stalls.
// The rate is set by the combinational state update between input and result registers.
// Reset is synchronous, active low, and returns the parser to the first header byte.
// When the result is not taken, one further byte waits in the input register and then
// the input side stalls until the result moves on.
`include "coap_message_parser_assert.svh"
module coap_message_parser
    import coap_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_event_res,
    output logic [7:0]  o_byte_value,
    output logic [1:0]  o_msg_type,
    output logic [7:0]  o_msg_code,
    output logic [15:0] o_msg_id,
    output logic [3:0]  o_token_len,
    output logic [15:0] o_option_number,
    output logic [15:0] o_option_length,
    output logic        o_done_res,
    output logic [1:0]  o_verdict
);

    logic    r_in_valid;
    logic    [7:0] r_in_byte;
    logic    r_in_last;
    t_state  r_st;
    t_state  n_st;
    logic    r_out_valid;
    t_result r_res;
    t_result n_res;
    logic    advance;
    logic    in_hdr;
    logic    opt_evt;
    logic    opt_clear;

    // The result register is free or is being emptied this cycle.
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;

    // Per-byte decode.
    coap_decode u_decode (
        .i_state     (r_st),
        .i_data_byte (r_in_byte),
        .i_is_last   (r_in_last),
        .o_state     (n_st),
        .o_result    (n_res)
    );

    // Control state and parser state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= state_reset();
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_st <= n_st;
                end
            end
        end
    end

    // Payload registers of both stages.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_is_last;
        end
        if (advance && r_in_valid) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_res     = r_res.event_res;
    assign o_byte_value    = r_res.byte_value;
    assign o_msg_type      = r_res.msg_type;
    assign o_msg_code      = r_res.msg_code;
    assign o_msg_id        = r_res.msg_id;
    assign o_token_len     = r_res.token_len;
    assign o_option_number = r_res.option_number;
    assign o_option_length = r_res.option_length;
    assign o_done_res      = r_res.done_res;
    assign o_verdict       = r_res.verdict;

    // Terms shared by the checks below.
    assign in_hdr    = (r_st.phase == PH_HDR);
    assign opt_evt   = (o_event_res == EV_OPT_BEGIN) || (o_event_res == EV_OPT_VALUE);
    assign opt_clear = (o_option_number == 16'd0) && (o_option_length == 16'd0);

    // The parser sits in the header phase exactly while the header is incomplete.
    `COAP_ASSERT(a_hdr_phase, i_clk, i_rst_n, in_hdr == (r_st.header_count < HDR_BYTES))
    // A token phase always has bytes left to take.
    `COAP_ASSERT(a_token_left, i_clk, i_rst_n, r_st.phase == PH_TOKEN |-> r_st.token_left != 4'd0)
    // A value phase always has bytes left to take.
    `COAP_ASSERT(a_value_left, i_clk, i_rst_n, r_st.phase == PH_VALUE |-> r_st.value_left != 16'd0)
    // Option fields are zero unless the result belongs to an option.
    `COAP_ASSERT(a_opt_fields, i_clk, i_rst_n, (o_out_valid && !opt_evt) |-> opt_clear)
    // A verdict is only given with the last byte.
    `COAP_ASSERT(a_verdict_done, i_clk, i_rst_n, o_out_valid && !o_done_res |-> o_verdict == 2'd0)

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the streaming CoAP message parser.
// Depends on coap_pkg and coap_message_parser; a built-in predictor checks every event.
`timescale 1ns / 1ps

module testbench;
    import coap_pkg::*;

    // Byte-level predictor of the parser together with the queue of expected events.
    class coap_parse_checker;
        t_result     expected_events[$];
        int unsigned mismatch_count;

        logic [3:0]  phase;
        logic [2:0]  hdr_count;
        logic [3:0]  tok_left;
        logic [15:0] opt_number;
        logic [15:0] delta_sum;
        logic [3:0]  len_nib;
        logic [15:0] len_sum;
        logic [15:0] val_left;
        logic [1:0]  hdr_type;
        logic [7:0]  hdr_code;
        logic [15:0] hdr_id;
        logic [3:0]  hdr_tkl;
        logic        bad_hdr;

        function new();
            mismatch_count = 0;
            clear();
        endfunction

        // Parser state at reset and at the start of every datagram.
        function void clear();
            phase      = PH_HDR;
            hdr_count  = '0;
            tok_left   = '0;
            opt_number = '0;
            delta_sum  = '0;
            len_nib    = '0;
            len_sum    = '0;
            val_left   = '0;
            hdr_type   = '0;
            hdr_code   = '0;
            hdr_id     = '0;
            hdr_tkl    = '0;
            bad_hdr    = 1'b0;
        endfunction

        // Returns 1 when the length needs no extension byte and the option header is complete.
        function bit begin_length();
            if (len_nib == EXT_ONE_NIB) begin
                phase = PH_L1;
                return 1'b0;
            end
            if (len_nib == EXT_TWO_NIB) begin
                phase = PH_LHI;
                return 1'b0;
            end
            len_sum = {12'd0, len_nib};
            return 1'b1;
        endfunction

        // Option header complete: advance the option number and arm the value count.
        function void close_option();
            opt_number = opt_number + delta_sum;
            val_left   = len_sum;
            phase      = (val_left != 16'd0) ? PH_VALUE : PH_OPT;
        endfunction

        function t_result parse_byte(logic [7:0] b, logic last);
            t_result r;
            bit      opt_shown;
            bit      hdr_seen;
            r         = '0;
            opt_shown = 1'b0;
            case (phase)
                PH_HDR: begin
                    case (hdr_count)
                        3'd0: begin
                            hdr_type = b[5:4];
                            hdr_tkl  = b[3:0];
                            bad_hdr  = (b[7:6] != COAP_VERSION) || (b[3:0] > TOKEN_MAX);
                        end
                        3'd1: hdr_code = b;
                        3'd2: hdr_id = {b, 8'h00};
                        default: hdr_id = hdr_id | {8'h00, b};
                    endcase
                    hdr_count = hdr_count + 3'd1;
                    if (hdr_count >= HDR_BYTES) begin
                        r.event_res = EV_HEADER;
                        if (bad_hdr) begin
                            phase = PH_SKIP;
                        end else begin
                            tok_left = hdr_tkl;
                            phase    = (tok_left != 4'd0) ? PH_TOKEN : PH_OPT;
                        end
                    end
                end
                PH_TOKEN: begin
                    r.event_res  = EV_TOKEN;
                    r.byte_value = b;
                    tok_left     = tok_left - 4'd1;
                    if (tok_left == 4'd0) phase = PH_OPT;
                end
                PH_OPT: begin
                    if (b == PAYLOAD_MARKER) begin
                        phase = PH_PAYLOAD;
                    end else begin
                        len_nib = b[3:0];
                        if (b[7:4] == EXT_ONE_NIB) begin
                            phase = PH_D1;
                        end else if (b[7:4] == EXT_TWO_NIB) begin
                            phase = PH_DHI;
                        end else begin
                            delta_sum = {12'd0, b[7:4]};
                            if (begin_length()) begin
                                close_option();
                                r.event_res = EV_OPT_BEGIN;
                                opt_shown   = 1'b1;
                            end
                        end
                    end
                end
                PH_D1, PH_DLO: begin
                    if (phase == PH_D1) delta_sum = EXT_ONE_BASE + {8'h00, b};
                    else delta_sum = EXT_TWO_BASE + (delta_sum | {8'h00, b});
                    if (begin_length()) begin
                        close_option();
                        r.event_res = EV_OPT_BEGIN;
                        opt_shown   = 1'b1;
                    end
                end
                PH_DHI: begin
                    delta_sum = {b, 8'h00};
                    phase     = PH_DLO;
                end
                PH_L1: begin
                    len_sum = EXT_ONE_BASE + {8'h00, b};
                    close_option();
                    r.event_res = EV_OPT_BEGIN;
                    opt_shown   = 1'b1;
                end
                PH_LHI: begin
                    len_sum = {b, 8'h00};
                    phase   = PH_LLO;
                end
                PH_LLO: begin
                    len_sum = EXT_TWO_BASE + (len_sum | {8'h00, b});
                    close_option();
                    r.event_res = EV_OPT_BEGIN;
                    opt_shown   = 1'b1;
                end
                PH_VALUE: begin
                    r.event_res  = EV_OPT_VALUE;
                    r.byte_value = b;
                    opt_shown    = 1'b1;
                    val_left     = val_left - 16'd1;
                    if (val_left == 16'd0) phase = PH_OPT;
                end
                PH_PAYLOAD: begin
                    r.event_res  = EV_PAYLOAD;
                    r.byte_value = b;
                end
                default: phase = PH_SKIP;
            endcase

            // Header fields show once all four header bytes are in.
            hdr_seen = (hdr_count >= HDR_BYTES);
            if (hdr_seen) begin
                r.msg_type  = hdr_type;
                r.msg_code  = hdr_code;
                r.msg_id    = hdr_id;
                r.token_len = hdr_tkl;
            end
            if (opt_shown) begin
                r.option_number = opt_number;
                r.option_length = len_sum;
            end

            // Verdict on the final byte, then back to the first header byte.
            if (last) begin
                r.done_res = 1'b1;
                if (!hdr_seen) r.verdict = VERDICT_RUNT;
                else if (bad_hdr) r.verdict = VERDICT_RESET;
                else if (phase == PH_OPT || phase == PH_PAYLOAD) r.verdict = VERDICT_OK;
                else r.verdict = VERDICT_RESET;
                clear();
            end
            return r;
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            expected_events.push_back(parse_byte(b, last));
        endfunction

        function int pending();
            return expected_events.size();
        endfunction

        task flag_mismatch(string what, logic [15:0] want, logic [15:0] got);
            mismatch_count++;
            $display("MISMATCH at %0t: %s expected %0h got %0h", $realtime, what, want, got);
        endtask

        task compare_field(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want) flag_mismatch(what, want, got);
        endtask

        // Compares one delivered event with the oldest expectation.
        task check_event(t_result got);
            t_result want;
            if (expected_events.size() == 0) begin
                flag_mismatch("event with nothing expected", '0, {13'd0, got.event_res});
            end else begin
                want = expected_events.pop_front();
                compare_field("event_res", 16'(want.event_res), 16'(got.event_res));
                compare_field("byte_value", 16'(want.byte_value), 16'(got.byte_value));
                compare_field("msg_type", 16'(want.msg_type), 16'(got.msg_type));
                compare_field("msg_code", 16'(want.msg_code), 16'(got.msg_code));
                compare_field("msg_id", want.msg_id, got.msg_id);
                compare_field("token_len", 16'(want.token_len), 16'(got.token_len));
                compare_field("option_number", want.option_number, got.option_number);
                compare_field("option_length", want.option_length, got.option_length);
                compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
                compare_field("verdict", 16'(want.verdict), 16'(got.verdict));
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_is_last;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [2:0]  o_event_res;
    logic [7:0]  o_byte_value;
    logic [1:0]  o_msg_type;
    logic [7:0]  o_msg_code;
    logic [15:0] o_msg_id;
    logic [3:0]  o_token_len;
    logic [15:0] o_option_number;
    logic [15:0] o_option_length;
    logic        o_done_res;
    logic [1:0]  o_verdict;

    coap_parse_checker book;
    logic [7:0]  frame_bytes[$];
    int unsigned send_gap_pct;
    int unsigned recv_gap_pct;
    int unsigned byte_count;
    int unsigned frame_count;
    int unsigned event_count;
    int unsigned long_budget;

    coap_message_parser DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_data_byte     (i_data_byte),
        .i_is_last       (i_is_last),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_res     (o_event_res),
        .o_byte_value    (o_byte_value),
        .o_msg_type      (o_msg_type),
        .o_msg_code      (o_msg_code),
        .o_msg_id        (o_msg_id),
        .o_token_len     (o_token_len),
        .o_option_number (o_option_number),
        .o_option_length (o_option_length),
        .o_done_res      (o_done_res),
        .o_verdict       (o_verdict)
    );

    always #5 i_clk = ~i_clk;

    // Receiver backpressure.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // Result monitor: values are stable at the falling edge, the transaction completes at
    // the next rising edge.
    always @(negedge i_clk) begin
        t_result got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.event_res     = o_event_res;
            got.byte_value    = o_byte_value;
            got.msg_type      = o_msg_type;
            got.msg_code      = o_msg_code;
            got.msg_id        = o_msg_id;
            got.token_len     = o_token_len;
            got.option_number = o_option_number;
            got.option_length = o_option_length;
            got.done_res      = o_done_res;
            got.verdict       = o_verdict;
            book.check_event(got);
            event_count++;
        end
    end

    // Presents one byte, with random gaps in front, and holds it until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_is_last   <= last;
        do @(negedge i_clk); while (!o_in_ready);
        book.note_byte(b, last);
        @(posedge i_clk);
        byte_count++;
    endtask

    task automatic send_frame();
        int unsigned k;
        for (k = 0; k < frame_bytes.size(); k++)
            send_byte(frame_bytes[k], k == frame_bytes.size() - 1);
        frame_count++;
    endtask

    // Holds the input side back until every expected event has been delivered.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (book.pending() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed datagrams with random content; some noise, bad headers and cuts.
    task automatic build_frame();
        int unsigned pick;
        int unsigned n_opts;
        int unsigned val_len;
        int unsigned k;
        int unsigned j;
        int unsigned cut;
        logic [3:0]  tkl;
        logic [3:0]  dnib;
        logic [3:0]  lnib;
        logic [7:0]  hi;
        logic [7:0]  lo;
        bit          long_val;
        frame_bytes.delete();
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            n_opts = $urandom_range(1, 10);
            for (k = 0; k < n_opts; k++) frame_bytes.push_back(8'($urandom));
            return;
        end
        tkl = (pick < 15) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
        frame_bytes.push_back({COAP_VERSION, 2'($urandom_range(0, 3)), tkl});
        for (k = 0; k < 3; k++) frame_bytes.push_back(8'($urandom));
        if (tkl <= TOKEN_MAX)
            for (k = 0; k < tkl; k++) frame_bytes.push_back(8'($urandom));

        n_opts = $urandom_range(0, 4);
        for (k = 0; k < n_opts; k++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: dnib = 4'($urandom_range(0, 12));
                6, 7: dnib = EXT_ONE_NIB;
                8: dnib = EXT_TWO_NIB;
                default: dnib = 4'd15;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: lnib = 4'($urandom_range(0, 12));
                7: lnib = EXT_ONE_NIB;
                8: lnib = 4'd15;
                default: lnib = EXT_TWO_NIB;
            endcase
            long_val = (long_budget != 0) && ($urandom_range(0, 7) == 0);
            frame_bytes.push_back({dnib, lnib});
            if (dnib == EXT_ONE_NIB) frame_bytes.push_back(8'($urandom));
            if (dnib == EXT_TWO_NIB) begin
                frame_bytes.push_back(8'($urandom));
                frame_bytes.push_back(8'($urandom));
            end
            val_len = 32'(lnib);
            if (lnib == EXT_ONE_NIB) begin
                if (long_val) long_budget--;
                lo = long_val ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 3));
                frame_bytes.push_back(lo);
                val_len = 13 + 32'(lo);
            end
            if (lnib == EXT_TWO_NIB) begin
                // Mostly lengths that wrap to small values; rarely a genuinely long one.
                if (long_val) begin
                    long_budget--;
                    if ($urandom_range(0, 1) == 0) begin
                        hi = 8'h00;
                        lo = 8'($urandom_range(0, 15));
                    end else begin
                        hi = 8'hFF;
                        lo = 8'($urandom_range(8'hF3, 8'hFF));
                    end
                end else begin
                    hi = 8'hFE;
                    lo = 8'($urandom_range(8'hF3, 8'hFF));
                end
                frame_bytes.push_back(hi);
                frame_bytes.push_back(lo);
                val_len = (int'({hi, lo}) + 269) % 65536;
            end
            for (j = 0; j < val_len; j++) frame_bytes.push_back(8'($urandom));
        end

        if ($urandom_range(0, 1) == 1) begin
            frame_bytes.push_back(PAYLOAD_MARKER);
            n_opts = $urandom_range(0, 8);
            for (k = 0; k < n_opts; k++) frame_bytes.push_back(8'($urandom));
        end

        // Truncated datagram, possibly down to a runt.
        if ($urandom_range(0, 99) < 15) begin
            cut = $urandom_range(1, frame_bytes.size());
            while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
        end
    endtask

    task automatic send_random(input int unsigned n_bytes);
        int unsigned start;
        start = byte_count;
        while (byte_count - start < n_bytes) begin
            build_frame();
            send_frame();
        end
    endtask

    // Run watchdog.
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int unsigned guard;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_data_byte  = '0;
        i_is_last    = 1'b0;
        send_gap_pct = 23;
        recv_gap_pct = 45;
        byte_count   = 0;
        frame_count  = 0;
        event_count  = 0;
        long_budget  = 2;
        book         = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Runt of a single byte.
        frame_bytes = '{8'h8F};
        send_frame();
        // Bad version and oversized token length: skipped after the header.
        frame_bytes = '{8'hCF, 8'h00, 8'h00, 8'h00, 8'h11};
        send_frame();
        // One token byte, one-byte delta extension, marker with no payload behind it.
        frame_bytes = '{8'h51, 8'h01, 8'h12, 8'h34, 8'hAB, 8'hD0, 8'hFF, 8'hFF};
        send_frame();
        // Two-byte extensions with a wrapping delta; cut short inside the option value.
        frame_bytes = '{8'h60, 8'h00, 8'h00, 8'h00, 8'hEE, 8'hFF, 8'hFF, 8'h00, 8'h01};
        send_frame();
        // Header extremes, nibble fifteen delta, one value byte and one payload byte.
        frame_bytes = '{8'h70, 8'hFF, 8'hFF, 8'hFF, 8'hF1, 8'h5A, 8'hFF, 8'h00};
        send_frame();

        send_random(420);
        wait_drained();

        send_gap_pct = 45;
        recv_gap_pct = 23;
        send_random(420);
        wait_drained();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        send_random(420);
        i_in_valid <= 1'b0;

        // Drain, then allow a few cycles for any stray event.
        guard = 0;
        while (book.pending() != 0 && guard < 20000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (book.pending() != 0)
            book.flag_mismatch("events never delivered", 16'(book.pending()), '0);

        $display("Run covered %0d datagrams, %0d bytes and %0d checked events", frame_count,
                 byte_count, event_count);
        $display("under three pacing mixes, with %0d mismatches.", book.mismatch_count);
        if (book.mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/coap_pkg.sv
rtl/coap_decode.sv
rtl/coap_message_parser.sv
dv/testbench.sv
